### hw/rtl/egfd_pkg.sv
// egfd_pkg: shared types, codes and the intra coded-block-pattern table
// for the exp-golomb field decoder; no dependencies
package egfd_pkg;

  localparam int OP_W     = 2;
  localparam int WIN_IN_W = 64;
  localparam int FLEN_W   = 6;
  localparam int VALUE_W  = 33;
  localparam int LEN_W    = 6;
  localparam int STATUS_W = 2;
  localparam int CODE_W   = 32;
  localparam int MAX_FIXED_LEN = 32;
  localparam int ME_LAST_CODE  = 47;

  typedef enum logic [OP_W-1:0] {
    OP_UE    = 2'd0,
    OP_SE    = 2'd1,
    OP_FIXED = 2'd2,
    OP_ME    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_PREFIX   = 2'd1,
    ST_ME_RANGE = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [LEN_W-1:0]          bits_consumed;
    status_e                   status;
  } result_t;

  // me(v) mapping for intra macroblocks
  function automatic logic [5:0] cbp_intra(input logic [5:0] code);
    logic [5:0] r;
    case (code)
      6'd0:  r = 6'd47;  6'd1:  r = 6'd31;  6'd2:  r = 6'd15;  6'd3:  r = 6'd0;
      6'd4:  r = 6'd23;  6'd5:  r = 6'd27;  6'd6:  r = 6'd29;  6'd7:  r = 6'd30;
      6'd8:  r = 6'd7;   6'd9:  r = 6'd11;  6'd10: r = 6'd13;  6'd11: r = 6'd14;
      6'd12: r = 6'd39;  6'd13: r = 6'd43;  6'd14: r = 6'd45;  6'd15: r = 6'd46;
      6'd16: r = 6'd16;  6'd17: r = 6'd3;   6'd18: r = 6'd5;   6'd19: r = 6'd10;
      6'd20: r = 6'd12;  6'd21: r = 6'd19;  6'd22: r = 6'd21;  6'd23: r = 6'd26;
      6'd24: r = 6'd28;  6'd25: r = 6'd35;  6'd26: r = 6'd37;  6'd27: r = 6'd42;
      6'd28: r = 6'd44;  6'd29: r = 6'd1;   6'd30: r = 6'd2;   6'd31: r = 6'd4;
      6'd32: r = 6'd8;   6'd33: r = 6'd17;  6'd34: r = 6'd18;  6'd35: r = 6'd20;
      6'd36: r = 6'd24;  6'd37: r = 6'd6;   6'd38: r = 6'd9;   6'd39: r = 6'd22;
      6'd40: r = 6'd25;  6'd41: r = 6'd32;  6'd42: r = 6'd33;  6'd43: r = 6'd34;
      6'd44: r = 6'd36;  6'd45: r = 6'd40;  6'd46: r = 6'd38;  6'd47: r = 6'd41;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/egfd_lzc.sv
// egfd_lzc: leading-zero counter over the head of the bit window
// depends on nothing
module egfd_lzc #(
  parameter int N = 32
) (
  input  logic [N-1:0]         bits_i,
  output logic [$clog2(N)-1:0] zeros_o,
  output logic                 all_zero_o
);

  always_comb begin
    zeros_o = '0;
    // higher bits override, so the first set bit from the top wins
    for (int i = 0; i < N; i++) begin
      if (bits_i[i]) begin
        zeros_o = ($clog2(N))'(N - 1 - i);
      end
    end
  end

  assign all_zero_o = (bits_i == '0);

endmodule

### hw/rtl/egfd_core.sv
// egfd_core: single-pass decode of one ue/se/u(n)/me element
// depends on egfd_pkg and egfd_lzc
module egfd_core
  import egfd_pkg::*;
#(
  parameter int WINDOW_BITS      = 64,
  parameter int MAX_PREFIX_ZEROS = 31
) (
  input  op_e                 op_i,
  input  logic [WIN_IN_W-1:0] bit_window_i,
  input  logic [FLEN_W-1:0]   field_length_i,
  output result_t             result_o
);

  localparam int K   = MAX_PREFIX_ZEROS + 1;
  localparam int KW  = (K < WINDOW_BITS) ? K : WINDOW_BITS;
  localparam int ZW  = $clog2(KW);
  localparam int SW  = $clog2(WINDOW_BITS + 1);
  localparam int CW  = SW + 1;
  localparam int CAP = (MAX_FIXED_LEN < WINDOW_BITS) ? MAX_FIXED_LEN : WINDOW_BITS;

  logic [WINDOW_BITS-1:0] win;
  logic [ZW-1:0]          zeros;
  logic                   all_zero;
  logic [ZW:0]            code_len;
  logic                   prefix_err;
  logic [CW-1:0]          sfx_shift;
  logic [WIN_IN_W-1:0]    sfx_bits;
  logic [CODE_W-1:0]      mask;
  logic [CODE_W-1:0]      code;
  logic [CODE_W-1:0]      half;
  logic [FLEN_W-1:0]      flen;
  logic [CW-1:0]          fix_shift;
  logic [WIN_IN_W-1:0]    fix_bits;
  logic [WIN_IN_W-1:0]    fix_mask;

  assign win = bit_window_i[WINDOW_BITS-1:0];

  egfd_lzc #(
    .N(KW)
  ) u_lzc (
    .bits_i    (win[WINDOW_BITS-1 -: KW]),
    .zeros_o   (zeros),
    .all_zero_o(all_zero)
  );

  // an all-zero head means either too many zeros or a code that overruns the window
  assign code_len   = {zeros, 1'b1};
  assign prefix_err = all_zero || (CW'(code_len) > CW'(WINDOW_BITS));

  assign sfx_shift = CW'(WINDOW_BITS - 1) - CW'({zeros, 1'b0});
  assign sfx_bits  = WIN_IN_W'(win) >> sfx_shift;
  assign mask      = CODE_W'((64'd1 << zeros) - 64'd1);
  assign code      = (sfx_bits[CODE_W-1:0] & mask) + mask;
  assign half      = code >> 1;

  assign flen      = (field_length_i > FLEN_W'(CAP)) ? FLEN_W'(CAP) : field_length_i;
  assign fix_shift = CW'(WINDOW_BITS) - CW'(flen);
  assign fix_bits  = WIN_IN_W'(win) >> fix_shift;
  assign fix_mask  = (64'd1 << flen) - 64'd1;

  always_comb begin
    result_o.value         = '0;
    result_o.bits_consumed = '0;
    result_o.status        = ST_OK;
    if (op_i == OP_FIXED) begin
      if (flen != '0) begin
        result_o.value = VALUE_W'(fix_bits & fix_mask);
      end
      result_o.bits_consumed = flen;
    end else if (prefix_err) begin
      result_o.status = ST_PREFIX;
    end else begin
      result_o.bits_consumed = LEN_W'(code_len);
      case (op_i)
        OP_UE: begin
          result_o.value = VALUE_W'(code);
        end
        OP_SE: begin
          if (code[0]) begin
            result_o.value = VALUE_W'(half + CODE_W'(1));
          end else begin
            result_o.value = -$signed(VALUE_W'(half));
          end
        end
        OP_ME: begin
          if (code > CODE_W'(ME_LAST_CODE)) begin
            result_o.status = ST_ME_RANGE;
          end else begin
            result_o.value = VALUE_W'(cbp_intra(code[5:0]));
          end
        end
        default: begin
          result_o.value = '0;
        end
      endcase
    end
  end

endmodule

### hw/rtl/exp_golomb_field_decoder.sv
// exp_golomb_field_decoder: top level, input and result registers around the decoder
// depends on egfd_pkg and egfd_core
//
// usage:
//   slave channel s_axis_*: one beat per syntax element. tdata carries the
//   next stream bits (first bit most significant) and the fixed-length bit
//   count, tuser the element kind (ue, se, u(n), me).
//   master channel m_axis_*: one beat per element with the decoded value and
//   the number of bits it used, so the parser can advance; tuser is status.
//   an accepted beat is decoded from the input register into the result register.
//   throughput: one element per cycle while m_axis_tready is high; the leading-zero
//   count and the suffix shift sit in one pass between the input and result registers.
//   stall: when m_axis_tready is low a pending result holds. If the input
//   register is empty it takes one more beat; once it is full s_axis_tready
//   stays low until the result is taken.
//   reset: rst_ni low empties both registers; no beat is pending afterwards.
//   no state is kept between elements.
module exp_golomb_field_decoder
  import egfd_pkg::*;
#(
  parameter int WINDOW_BITS      = 64,
  parameter int MAX_PREFIX_ZEROS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // bit_window[63:0], field_length[69:64], zero pad
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // value[32:0], bits_consumed[38:33], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  logic                in_valid_q;
  op_e                 in_op_q;
  logic [WIN_IN_W-1:0] in_win_q;
  logic [FLEN_W-1:0]   in_flen_q;
  logic                out_valid_q;
  result_t             out_q;
  result_t             res_d;
  logic                advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  egfd_core #(
    .WINDOW_BITS     (WINDOW_BITS),
    .MAX_PREFIX_ZEROS(MAX_PREFIX_ZEROS)
  ) u_core (
    .op_i          (in_op_q),
    .bit_window_i  (in_win_q),
    .field_length_i(in_flen_q),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= op_e'(s_axis_tuser);
      in_win_q  <= s_axis_tdata[63:0];
      in_flen_q <= s_axis_tdata[69:64];
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.bits_consumed, out_q.value};
  assign m_axis_tuser  = out_q.status;

endmodule

### sim/testbench.sv
// testbench for exp_golomb_field_decoder: ue/se/u(n)/me elements streamed in with
// random gaps and back-pressure, every result checked against a local decoder model
// depends on egfd_pkg and the exp_golomb_field_decoder rtl
`timescale 1ns / 100ps

module testbench;
  import egfd_pkg::*;

  localparam int WIN_BITS     = 64;
  localparam int PREFIX_LIMIT = 31;
  localparam int GAP_MAX      = 17;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ELEMENTS = 800;

  // intra coded-block-pattern mapping for me(v), indexed by code number
  localparam logic [5:0] ME_INTRA_MAP [48] = '{
    6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
    6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
    6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
    6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
    6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
    6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
  };

  typedef struct {
    op_e         op;
    logic [63:0] window;
    logic [5:0]  flen;
    int          gap;
    bit          drain;   // hold back until every earlier element is decoded
  } element_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // bit_window[63:0], field_length[69:64], zero pad
  logic [1:0]  s_axis_tuser = '0;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // value[32:0], bits_consumed[38:33], zero pad
  logic [1:0]  m_axis_tuser;        // status[1:0]

  element_t stream_elements[$];
  result_t  pending_decodes[$];

  int elements_queued = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int fails = 0;
  int cycles = 0;

  element_t staged_element;
  bit       staged = 1'b0;
  int       gap_left = 0;
  int       stall_left = 0;

  exp_golomb_field_decoder #(
    .WINDOW_BITS     (WIN_BITS),
    .MAX_PREFIX_ZEROS(PREFIX_LIMIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // zeros leading zeros, the marker one, a zeros-bit suffix (up to 31 zeros), then random tail bits
  function automatic logic [63:0] code_window(input int zeros, input logic [63:0] suffix);
    logic [63:0] w;
    logic [63:0] mask;
    if (zeros > 63) begin
      return '0;
    end
    w = rand64() >> (zeros + 1);
    w[63-zeros] = 1'b1;
    if (zeros <= 31) begin
      mask = ((64'd1 << zeros) - 64'd1) << (63 - 2 * zeros);
      w = (w & ~mask) | ((suffix << (63 - 2 * zeros)) & mask);
    end
    return w;
  endfunction

  function automatic result_t decode_syntax_element(input op_e op, input logic [63:0] win,
                                                    input logic [5:0] flen);
    result_t     r;
    int          zeros;
    int          n;
    logic [63:0] suffix;
    logic [63:0] code;
    logic [63:0] tmp;
    r = '0;
    r.status = ST_OK;
    zeros = 0;
    if (op == OP_FIXED) begin
      n = (flen > MAX_FIXED_LEN) ? MAX_FIXED_LEN : int'(flen);
      if (n > WIN_BITS) n = WIN_BITS;
      if (n > 0) begin
        tmp = win >> (WIN_BITS - n);
        r.value = tmp[32:0];
      end
      r.bits_consumed = n[5:0];
    end else begin
      while (zeros < WIN_BITS && win[WIN_BITS-1-zeros] == 1'b0) zeros++;
      if (zeros > PREFIX_LIMIT || 2 * zeros + 1 > WIN_BITS) begin
        r.status = ST_PREFIX;
      end else begin
        suffix = (win >> (WIN_BITS - 1 - 2 * zeros)) & ((64'd1 << zeros) - 64'd1);
        code = ((64'd1 << zeros) - 64'd1) + suffix;
        r.bits_consumed = 6'(2 * zeros + 1);
        case (op)
          OP_UE: begin
            r.value = code[32:0];
          end
          OP_SE: begin
            // odd code numbers are positive, even ones zero or negative
            if (code[0]) tmp = (code + 64'd1) >> 1;
            else tmp = 64'd0 - (code >> 1);
            r.value = tmp[32:0];
          end
          default: begin
            if (code > ME_LAST_CODE) begin
              r.status = ST_ME_RANGE;
            end else begin
              r.value = {27'd0, ME_INTRA_MAP[code[5:0]]};
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  task automatic add_element(input op_e op, input logic [63:0] win, input int flen,
                             input bit drain);
    element_t e;
    e.op = op;
    e.window = win;
    e.flen = flen[5:0];
    // every third stretch of sixty elements goes without sender gaps
    e.gap = ((elements_queued / 60) % 3 == 0) ? 0 : $urandom_range(0, GAP_MAX);
    e.drain = drain;
    stream_elements.push_back(e);
    elements_queued++;
  endtask

  // sender: one element staged at a time, sent after its gap
  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit accept;
    bit next_valid;
    int sent_now;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_UE;
    end else begin
      accept = s_axis_tvalid && s_axis_tready;
      sent_now = beats_sent + (accept ? 1 : 0);
      next_valid = s_axis_tvalid && !accept;
      if (accept) beats_sent <= sent_now;
      if (!next_valid) begin
        if (!staged && stream_elements.size() > 0) begin
          staged_element = stream_elements.pop_front();
          staged = 1'b1;
          gap_left = staged_element.gap;
        end
        if (staged) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!(staged_element.drain && sent_now != results_seen)) begin
            s_axis_tdata <= {2'b00, staged_element.flen, staged_element.window};
            s_axis_tuser <= staged_element.op;
            next_valid = 1'b1;
            staged = 1'b0;
          end
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // receiver: checks each result beat, records the prediction for each accepted input beat
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t              want;
    logic signed [32:0]   got_value;
    logic [5:0]           got_len;
    logic [1:0]           got_status;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_value = m_axis_tdata[32:0];
        got_len = m_axis_tdata[38:33];
        got_status = m_axis_tuser;
        if (pending_decodes.size() == 0) begin
          $error("result beat with no element outstanding");
          fails++;
        end else begin
          want = pending_decodes.pop_front();
          if (got_value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, got_value);
            fails++;
          end
          if (got_len !== want.bits_consumed) begin
            $error("bits_consumed: expected %0d, got %0d", want.bits_consumed, got_len);
            fails++;
          end
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            fails++;
          end
        end
        results_seen <= results_seen + 1;
        // stalls pause for one stretch of fifty results in three
        stall_left = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_decodes.push_back(decode_syntax_element(op_e'(s_axis_tuser),
                                                        s_axis_tdata[63:0],
                                                        s_axis_tdata[69:64]));
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int     kind;
    int     zeros;
    int     flen;
    op_e    op;
    logic [63:0] win;

    // directed: code extremes, sign mapping, fixed-length saturation, me range
    add_element(OP_UE, code_window(0, 64'd0), 0, 1'b0);
    add_element(OP_UE, 64'd0, 5, 1'b0);
    add_element(OP_UE, code_window(31, '1), 0, 1'b0);
    add_element(OP_UE, code_window(32, 64'd0), 0, 1'b0);
    add_element(OP_UE, code_window(63, 64'd0), 0, 1'b0);
    add_element(OP_SE, code_window(1, 64'd0), 0, 1'b0);
    add_element(OP_SE, code_window(1, 64'd1), 0, 1'b0);
    add_element(OP_SE, code_window(31, '1), 0, 1'b0);
    add_element(OP_SE, code_window(31, 64'hFFFF_FFFE), 0, 1'b0);
    add_element(OP_SE, code_window(31, 64'd0), 0, 1'b0);
    add_element(OP_SE, code_window(0, 64'd0), 0, 1'b0);
    add_element(OP_SE, 64'd0, 0, 1'b0);
    add_element(OP_FIXED, '1, 0, 1'b0);
    add_element(OP_FIXED, '1, 1, 1'b0);
    add_element(OP_FIXED, '1, 32, 1'b0);
    add_element(OP_FIXED, '1, 33, 1'b0);
    add_element(OP_FIXED, 64'd0, 63, 1'b0);
    add_element(OP_FIXED, rand64(), 32, 1'b0);
    add_element(OP_ME, code_window(0, 64'd0), 0, 1'b0);
    add_element(OP_ME, code_window(5, 64'd16), 0, 1'b0);
    add_element(OP_ME, code_window(5, 64'd17), 0, 1'b0);
    add_element(OP_ME, code_window(31, '1), 0, 1'b0);
    add_element(OP_ME, 64'd0, 0, 1'b0);
    add_element(OP_UE, code_window(15, rand64()), 0, 1'b1);

    for (int i = 0; i < RANDOM_ELEMENTS; i++) begin
      kind = $urandom_range(0, 99);
      op = op_e'($urandom_range(0, 3));
      flen = (kind < 80) ? $urandom_range(0, 32) : $urandom_range(0, 63);
      if (kind < 10) begin
        win = rand64();
      end else begin
        if (kind < 15) zeros = $urandom_range(32, 64);
        else if (kind < 30) zeros = $urandom_range(9, 31);
        else zeros = $urandom_range(0, 8);
        win = code_window(zeros, rand64());
      end
      add_element(op, win, flen, i == RANDOM_ELEMENTS / 2);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stream_elements.size() != 0 || staged || s_axis_tvalid) @(posedge clk_i);
    while (results_seen != beats_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_decodes.size() != 0) begin
      $error("%0d elements never decoded", pending_decodes.size());
      fails++;
    end
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
